>>> src/point_set_min_max_normalizer_assert.svh
// Assertion macros for the point set min/max normalizer.
// Expects signals named clk and arst_n in the scope of every use.
`ifndef POINT_SET_MIN_MAX_NORMALIZER_ASSERT_SVH
`define POINT_SET_MIN_MAX_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/psnorm_pkg.sv
// Package of the point set min/max normalizer: widths, codes, state and
// command types shared by the modules and interfaces. No dependencies.
`timescale 1ns / 1ps

package psnorm_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int COORD_W = 16;
	localparam int VAL_W   = 32;
	localparam int MV_W    = 16;
	localparam int QUO_W   = 16;
	localparam int NUM_W   = VAL_W + MV_W;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);

	localparam logic [MV_W-1:0] MAX_VALUE_RESET = 16'hFF;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV_START,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [VAL_W-1:0]   v;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic read_start;
		logic prep;
		logic mul;
		logic div_start;
		logic out_read;
	} cmd_t;

	typedef struct packed {
		logic read_avail;
		logic div_done;
	} sts_t;

endpackage

>>> src/psnorm_req_if.sv
// Request channel interface: valid, ready and the request payload.
// Depends on psnorm_pkg for field widths.
`timescale 1ns / 1ps

interface psnorm_req_if
	import psnorm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic [VAL_W-1:0]   point_value;

	modport source (output valid, req_type, point_x, point_y, point_value, input ready);
	modport sink (input valid, req_type, point_x, point_y, point_value, output ready);
endinterface

>>> src/psnorm_rsp_if.sv
// Result channel interface: valid, ready and the result payload.
// Depends on psnorm_pkg for field widths.
`timescale 1ns / 1ps

interface psnorm_rsp_if
	import psnorm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic [QUO_W-1:0]   out_value;
	logic               out_last;
	logic               overflow;

	modport source (output valid, out_x, out_y, out_value, out_last, overflow, input ready);
	modport sink (input valid, out_x, out_y, out_value, out_last, overflow, output ready);
endinterface

>>> src/point_set_min_max_normalizer.sv
// Top level of the point set min/max normalizer: joins controller and datapath.
// Depends on psnorm_pkg, both channel interfaces, psnorm_ctrl, psnorm_dp and
// the assertion macro header.
//
// Requests arrive on req_ch as valid/ready transfers. A load stores a point and
// updates the minima and the value maximum; it yields one result whose
// overflow bit tells that the store of MAX_POINTS entries was full. A read
// returns the next stored point, shifted by the minima, with its value scaled
// into 0 to max_value. A clear, an exhausted read and request code three give
// no result. Results leave on rsp_ch through one output register.
// Loads, clears and empty reads are handled without leaving the idle state; a
// result of a load appears in the cycle after its transfer. A read passes through
// memory read, operand preparation, a 32 by 16 multiply and the 16-step radix-2
// divider before its result is registered. One read is worked on at a time: no
// request is taken until its result is registered. When the receiver stalls,
// the result waits in the output register and a new request is taken only if
// that register is free or drains in the same cycle. Reset clears counts,
// minima, maximum and the valid flag and sets max_value to 255; cfg_we writes it.
`timescale 1ns / 1ps
`include "point_set_min_max_normalizer_assert.svh"

module point_set_min_max_normalizer
	import psnorm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	psnorm_req_if.sink      req_ch,
	psnorm_rsp_if.source    rsp_ch,
	input  logic            cfg_we,
	input  logic [MV_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	psnorm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_type  (req_ch.req_type),
		.req_ready (req_ch.ready),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	psnorm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.point_x     (req_ch.point_x),
		.point_y     (req_ch.point_y),
		.point_value (req_ch.point_value),
		.out_x       (rsp_ch.out_x),
		.out_y       (rsp_ch.out_y),
		.out_value   (rsp_ch.out_value),
		.out_last    (rsp_ch.out_last),
		.overflow    (rsp_ch.overflow)
	);

	`PSN_ASSERT_NEXT(a_read_blocks_input, cmd.read_start, !req_ch.ready, "request taken during read")
	`PSN_ASSERT_NOW(a_div_done_busy, sts.div_done, !req_ch.ready, "divider done while idle")
	`PSN_ASSERT_NOW(a_no_overwrite, cmd.out_read, !rsp_ch.valid || rsp_ch.ready, "result overwritten")
	`PSN_ASSERT_NEXT(a_load_result, cmd.load, rsp_ch.valid, "load result missing")

endmodule

>>> src/psnorm_div.sv
// Radix-2 restoring divider producing a QUO_W-bit quotient, one bit a cycle.
// Depends on psnorm_pkg; the dividend must be below the divisor times 2^QUO_W.
`timescale 1ns / 1ps

module psnorm_div
	import psnorm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [VAL_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             done
);

	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     dvs_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 ge;
	logic [NUM_W-1:0]     diff;

	assign ge   = rem_q >= dvs_q;
	assign diff = rem_q - dvs_q;
	assign quo  = quo_q;
	assign done = busy_q && (cnt_q == DIV_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dvs_q <= NUM_W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

>>> src/psnorm_dp.sv
// Datapath: point memory, running minima and maximum, scaling operands,
// the divider and the result register. Depends on psnorm_pkg and psnorm_div.
`timescale 1ns / 1ps

module psnorm_dp
	import psnorm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [MV_W-1:0]    cfg_wdata,
	input  logic [COORD_W-1:0] point_x,
	input  logic [COORD_W-1:0] point_y,
	input  logic [VAL_W-1:0]   point_value,
	output logic [COORD_W-1:0] out_x,
	output logic [COORD_W-1:0] out_y,
	output logic [QUO_W-1:0]   out_value,
	output logic               out_last,
	output logic               overflow
);

	entry_t             mem [MAX_POINTS];
	entry_t             rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   read_index_q;
	logic [COORD_W-1:0] x_min_q;
	logic [COORD_W-1:0] y_min_q;
	logic [VAL_W-1:0]   v_min_q;
	logic [VAL_W-1:0]   v_max_q;
	logic [MV_W-1:0]    max_value_q;
	logic               last_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [VAL_W-1:0]   a_q;
	logic [VAL_W-1:0]   den_q;
	logic [NUM_W-1:0]   prod_q;
	logic [QUO_W-1:0]   quo;
	logic               div_done;
	logic               full;
	logic               store;
	logic [VAL_W-1:0]   v_range;
	logic [CNT_W-1:0]   next_index;

	assign full       = count_q == CNT_W'(MAX_POINTS);
	assign store      = cmd.load && !full;
	assign v_range    = v_max_q - v_min_q;
	assign next_index = read_index_q + CNT_W'(1);

	assign sts.read_avail = read_index_q < count_q;
	assign sts.div_done   = div_done;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[ADDR_W-1:0]] <= '{x: point_x, y: point_y, v: point_value};
		end
		rd_q <= mem[read_index_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			read_index_q <= '0;
			x_min_q      <= '0;
			y_min_q      <= '0;
			v_min_q      <= '0;
			v_max_q      <= '0;
			max_value_q  <= MAX_VALUE_RESET;
		end else begin
			if (cfg_we) begin
				max_value_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				count_q      <= '0;
				read_index_q <= '0;
				x_min_q      <= '0;
				y_min_q      <= '0;
				v_min_q      <= '0;
				v_max_q      <= '0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					x_min_q <= point_x;
					y_min_q <= point_y;
					v_min_q <= point_value;
					v_max_q <= point_value;
				end else begin
					if ($signed(point_x) < $signed(x_min_q)) begin
						x_min_q <= point_x;
					end
					if ($signed(point_y) < $signed(y_min_q)) begin
						y_min_q <= point_y;
					end
					if (point_value < v_min_q) begin
						v_min_q <= point_value;
					end
					if (point_value > v_max_q) begin
						v_max_q <= point_value;
					end
				end
			end else if (cmd.read_start) begin
				read_index_q <= next_index;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_start) begin
			last_q <= next_index == count_q;
		end
		if (cmd.prep) begin
			dx_q <= rd_q.x - x_min_q;
			dy_q <= rd_q.y - y_min_q;
			if (v_range != '0) begin
				a_q   <= rd_q.v - v_min_q;
				den_q <= v_range;
			end else begin
				a_q   <= rd_q.v;
				den_q <= v_max_q;
			end
		end
		if (cmd.mul) begin
			prod_q <= NUM_W'(a_q) * NUM_W'(max_value_q);
		end
	end

	psnorm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (den_q),
		.quo    (quo),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_x     <= '0;
			out_y     <= '0;
			out_value <= '0;
			out_last  <= 1'b0;
			overflow  <= full;
		end else if (cmd.out_read) begin
			out_x     <= dx_q;
			out_y     <= dy_q;
			out_value <= (den_q == '0) ? '0 : quo;
			out_last  <= last_q;
			overflow  <= 1'b0;
		end
	end

endmodule

>>> src/psnorm_ctrl.sv
// Controller state machine: request handshake, read sequencing and the
// result valid flag. Depends on psnorm_pkg.
`timescale 1ns / 1ps

module psnorm_ctrl
	import psnorm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && out_free && (req_type == REQ_READ) && sts.read_avail) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:      state_d = ST_MUL;
			ST_MUL:       state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				case (req_type)
					REQ_LOAD:  cmd.load = req_valid && out_free;
					REQ_READ:  cmd.read_start = req_valid && out_free && sts.read_avail;
					REQ_CLEAR: cmd.clear = req_valid && out_free;
					default:   cmd = '0;
				endcase
			end
			ST_PREP:      cmd.prep = 1'b1;
			ST_MUL:       cmd.mul = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV:       cmd = '0;
			ST_FINISH:    cmd.out_read = out_free;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load || cmd.out_read) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
